// ----- design/gedt_pkg.sv -----
// ----------------------------------------------------------------------------
// gedt_pkg
// Shared types and constants of the 3x3 gradient edge threshold unit.
// ----------------------------------------------------------------------------
package gedt_pkg;

  // line store depth and address width
  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  // reset values and limits of the registers
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam logic [8:0]  THR_RESET    = 9'd100;
  localparam logic [10:0] WIDTH_MIN    = 11'd3;
  localparam logic [10:0] WIDTH_MAX    = 11'(MaxWidth);
  localparam logic [15:0] HEIGHT_MIN   = 16'd3;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  // front to back queue
  localparam int CmdDepth = 4;
  localparam int CmdAw    = $clog2(CmdDepth);

  // result queue
  localparam int ResDepth = 8;
  localparam int ResAw    = $clog2(ResDepth);

  typedef struct packed {
    logic [10:0] width;   // clamped to 3..MaxWidth
    logic [15:0] height;  // clamped to at least 3
    logic [21:0] lim;     // 9 * threshold^2
  } cfg_t;

  typedef struct packed {
    logic            produce;
    logic [ColW-1:0] cc;
    logic [15:0]     rr;
    logic            last;
  } tag_t;

  typedef struct packed {
    logic [7:0]      pixel;
    logic [ColW-1:0] col;
    tag_t            tag;
  } cmd_t;

  typedef struct packed {
    logic            hit;
    logic [ColW-1:0] cc;
    logic [15:0]     rr;
    logic            last;
  } res_t;

endpackage

// ----- design/gedt_front.sv -----
// ----------------------------------------------------------------------------
// gedt_front
// Tracks the raster position of each pixel and classifies it: line store
// column, whether it completes an interior window, and the result position.
// ----------------------------------------------------------------------------
module gedt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  gedt_pkg::cfg_t             cfg,
  input  logic                       push,
  input  logic [7:0]                 pixel,
  input  logic                       frame_start,
  input  logic                       queue_full,
  output logic                       cmd_push,
  output gedt_pkg::cmd_t             cmd
);

  logic [gedt_pkg::ColW-1:0] col_count, col_count_next;
  logic [15:0]               row_count, row_count_next;

  logic [gedt_pkg::ColW-1:0] col_s, col_e;
  logic [15:0]               row_s, row_e;
  logic [16:0]               row_inc, row_wrap;
  logic [10:0]               col_inc;

  assign cmd_push = push && !queue_full;

  always_comb begin
    col_s = frame_start ? '0 : col_count;
    row_s = frame_start ? '0 : row_count;

    // position left over from a larger width starts the next row
    if ({1'b0, col_s} >= cfg.width) begin
      col_e   = '0;
      row_inc = {1'b0, row_s} + 17'd1;
    end else begin
      col_e   = col_s;
      row_inc = {1'b0, row_s};
    end
    row_e = (row_inc >= {1'b0, cfg.height}) ? 16'd0 : row_inc[15:0];

    cmd.pixel       = pixel;
    cmd.col         = col_e;
    cmd.tag.produce = (col_e >= gedt_pkg::ColW'(2)) && (row_e >= 16'd2);
    cmd.tag.cc      = col_e - gedt_pkg::ColW'(1);
    cmd.tag.rr      = row_e - 16'd1;
    cmd.tag.last    = ({1'b0, cmd.tag.cc} == (cfg.width - 11'd2))
                      && (cmd.tag.rr == (cfg.height - 16'd2));

    col_inc = {1'b0, col_e} + 11'd1;
    if (col_inc >= cfg.width) begin
      col_count_next = '0;
      row_wrap       = {1'b0, row_e} + 17'd1;
      row_count_next = (row_wrap >= {1'b0, cfg.height}) ? 16'd0 : row_wrap[15:0];
    end else begin
      col_count_next = col_inc[gedt_pkg::ColW-1:0];
      row_wrap       = {1'b0, row_e};
      row_count_next = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd_push) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

// ----- design/gedt_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// gedt_cmd_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module gedt_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  gedt_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output gedt_pkg::cmd_t rd_data,
  output logic           empty
);

  gedt_pkg::cmd_t              slots [gedt_pkg::CmdDepth];
  logic [gedt_pkg::CmdAw-1:0]  wr_ptr, rd_ptr;
  logic [gedt_pkg::CmdAw:0]    count;

  assign full    = (count == (gedt_pkg::CmdAw+1)'(gedt_pkg::CmdDepth));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("command queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + 1'b1))
    else $error("command queue count did not follow a lone write");
`endif

endmodule

// ----- design/gedt_back.sv -----
// ----------------------------------------------------------------------------
// gedt_back
// Line store, 3x3 window, gradient and threshold pipeline, result queue.
// ----------------------------------------------------------------------------
module gedt_back (
  input  logic                       clk,
  input  logic                       rst,
  input  gedt_pkg::cfg_t             cfg,
  input  logic                       cmd_empty,
  input  gedt_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       pop,
  output logic                       empty,
  output gedt_pkg::res_t             res
);

  // line store word: {upper row, middle row}
  logic [15:0] mem [gedt_pkg::MaxWidth];
  logic [15:0] mem_rd;
  logic        byp;
  logic [15:0] byp_data;

  // stage a: store data ready, window and gradients
  logic                      a_valid;
  logic [7:0]                a_pixel;
  logic [gedt_pkg::ColW-1:0] a_col;
  gedt_pkg::tag_t            a_tag;

  // stage b: absolute gradients
  logic           b_valid;
  gedt_pkg::tag_t b_tag;
  logic [9:0]     b_ax, b_ay;

  // stage c: squares
  logic           c_valid;
  gedt_pkg::tag_t c_tag;
  logic [19:0]    c_sx, c_sy;

  logic [7:0]  win [6];
  logic [7:0]  t2, m2;
  logic [15:0] wr_word;
  logic [9:0]  s_right, s_left, s_bot, s_top;
  logic [10:0] gx, gy;
  logic [9:0]  ax, ay;
  logic [20:0] mag;

  // result queue
  gedt_pkg::res_t              rq [gedt_pkg::ResDepth];
  logic [gedt_pkg::ResAw-1:0]  rq_wr, rq_rd;
  logic [gedt_pkg::ResAw:0]    rq_count;
  logic [gedt_pkg::ResAw+1:0]  reserved;
  logic                        res_push, res_pop;
  gedt_pkg::res_t              res_in;

  // only take a pixel when the result queue has room for everything in flight
  assign reserved = {1'b0, rq_count} + (gedt_pkg::ResAw+2)'(a_valid)
                    + (gedt_pkg::ResAw+2)'(b_valid) + (gedt_pkg::ResAw+2)'(c_valid);
  assign cmd_pop  = !cmd_empty && (reserved < (gedt_pkg::ResAw+2)'(gedt_pkg::ResDepth));

  // line store, with forwarding of the word written in the same cycle
  always_ff @(posedge clk) begin
    if (a_valid) begin
      mem[a_col] <= wr_word;
    end
    if (cmd_pop) begin
      mem_rd   <= mem[cmd.col];
      byp      <= a_valid && (a_col == cmd.col);
      byp_data <= wr_word;
    end
  end

  always_comb begin
    {t2, m2} = byp ? byp_data : mem_rd;
    wr_word  = {m2, a_pixel};

    s_right = {2'b0, t2} + {1'b0, m2, 1'b0} + {2'b0, a_pixel};
    s_left  = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
    s_bot   = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, a_pixel};
    s_top   = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, t2};
    gx      = {1'b0, s_right} - {1'b0, s_left};
    gy      = {1'b0, s_bot} - {1'b0, s_top};
    ax      = gx[10] ? 10'(-gx) : gx[9:0];
    ay      = gy[10] ? 10'(-gy) : gy[9:0];

    mag           = {1'b0, c_sx} + {1'b0, c_sy};
    res_in.hit    = ({1'b0, mag} > cfg.lim);
    res_in.cc     = c_tag.cc;
    res_in.rr     = c_tag.rr;
    res_in.last   = c_tag.last;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_pixel <= cmd.pixel;
      a_col   <= cmd.col;
      a_tag   <= cmd.tag;
    end
    b_tag <= a_tag;
    b_ax  <= ax;
    b_ay  <= ay;
    c_tag <= b_tag;
    c_sx  <= {10'b0, b_ax} * {10'b0, b_ax};
    c_sy  <= {10'b0, b_ay} * {10'b0, b_ay};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      a_valid <= cmd_pop;
      b_valid <= a_valid;
      c_valid <= b_valid;
      if (a_valid) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= t2;
        win[4] <= m2;
        win[5] <= a_pixel;
      end
    end
  end

  assign res_push = c_valid && c_tag.produce;
  assign res_pop  = pop && !empty;
  assign empty    = (rq_count == '0);
  assign res      = rq[rq_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      if (res_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (res_pop) begin
        rq_rd <= rq_rd + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   rq_count <= rq_count + 1'b1;
        2'b01:   rq_count <= rq_count - 1'b1;
        default: rq_count <= rq_count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= (gedt_pkg::ResAw+2)'(gedt_pkg::ResDepth))
    else $error("result queue oversubscribed");
  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (a_valid == $past(cmd_pop)))
    else $error("stage a does not follow the pop");
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (c_tag.cc != '0) && (c_tag.rr != 16'd0))
    else $error("result pushed for a border pixel");
`endif

endmodule

// ----- design/gradient_edge_threshold_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// gradient_edge_threshold_3x3_unit
// Thresholded 3x3 gradient edge detector over an 8-bit grey pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on pixel/frame_start; a beat is taken when
// push is high and full is low. frame_start puts that pixel at column 0,
// row 0. One result beat leaves for each interior centre pixel while empty
// is low; pop takes it. Border pixels give no result.
// Throughput is one pixel per clock while the back is taking pixels. Each
// result passes through the command queue, line store read, gradient,
// squares and compare into the result queue. The line store can take one read
// and one write in the same cycle, which sets the one-pixel-per-cycle figure.
// When pop stays low the result queue fills, the back stops taking pixels,
// the command queue fills and full rises; nothing is dropped.
// Registers must be written through cfg_write/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Reset (rst,
// synchronous) empties both queues, clears the window and the position and
// loads width 640, height 480, threshold 100. The line store is not cleared;
// the first two rows of a frame fill it before any result depends on it.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_3x3_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  edge_value,
  output logic [9:0]  column,
  output logic [15:0] row,
  output logic        frame_last
);

  gedt_pkg::cfg_t cfg;
  logic [8:0]     thr;
  logic [17:0]    thr_sq;
  logic [10:0]    width_in;
  logic [15:0]    height_in;

  logic           cmd_push, cmd_pop, cmd_empty;
  gedt_pkg::cmd_t cmd_in, cmd_out;
  gedt_pkg::res_t res;

  assign width_in  = cfg_data[10:0];
  assign height_in = cfg_data[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= gedt_pkg::WIDTH_RESET;
      cfg.height <= gedt_pkg::HEIGHT_RESET;
      thr        <= gedt_pkg::THR_RESET;
      thr_sq     <= {9'b0, gedt_pkg::THR_RESET} * {9'b0, gedt_pkg::THR_RESET};
      cfg.lim    <= 22'(9 * gedt_pkg::THR_RESET * gedt_pkg::THR_RESET);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          gedt_pkg::REG_IMAGE_WIDTH: begin
            if (width_in < gedt_pkg::WIDTH_MIN) begin
              cfg.width <= gedt_pkg::WIDTH_MIN;
            end else if (width_in > gedt_pkg::WIDTH_MAX) begin
              cfg.width <= gedt_pkg::WIDTH_MAX;
            end else begin
              cfg.width <= width_in;
            end
          end
          gedt_pkg::REG_IMAGE_HEIGHT: begin
            cfg.height <= (height_in < gedt_pkg::HEIGHT_MIN) ? gedt_pkg::HEIGHT_MIN
                                                              : height_in;
          end
          gedt_pkg::REG_THRESHOLD: begin
            thr <= cfg_data[8:0];
          end
          default: begin
          end
        endcase
      end
      // 9 * th^2 as 8x + x
      thr_sq  <= {9'b0, thr} * {9'b0, thr};
      cfg.lim <= {1'b0, thr_sq, 3'b000} + {4'b0, thr_sq};
    end
  end

  gedt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .pixel       (pixel),
    .frame_start (frame_start),
    .queue_full  (full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  gedt_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd      (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  gedt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign edge_value = res.hit ? gedt_pkg::EDGE_ON : gedt_pkg::EDGE_OFF;
  assign column     = res.cc;
  assign row        = res.rr;
  assign frame_last = res.last;

endmodule
